/* rtl/wmf_pkg.sv */
// Shared types and constants for the 3x3 window median filter.
// Used by every module in the rtl folder; depends on nothing.
`default_nettype none

package wmf_pkg;

   localparam int unsigned WIN_SIZE     = 9;
   localparam int unsigned WIN_IDX_W    = $clog2(WIN_SIZE);
   localparam int unsigned PRIME_PIXELS = 6;
   localparam int unsigned MAX_COLUMNS  = 4096;
   localparam int unsigned CFG_W        = 13;
   localparam int unsigned COL_W        = 12;
   localparam int unsigned CFG_RESET    = 512;
   localparam int unsigned QUEUE_DEPTH  = 2;

   typedef logic [7:0] grey_type;
   typedef grey_type [WIN_SIZE-1:0] window_type;

   typedef enum logic [1:0] {
      OP_PRIME,
      OP_ROW_START,
      OP_SHIFT
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [2:0]  slot;
      logic        last;
      grey_type    grey;
   } op_type;

endpackage

`default_nettype wire

/* rtl/window_median_filter_3x3_core.sv */
// Top level of the 3x3 window median filter: front end, operation queue,
// window store and median pipe. Depends on wmf_pkg and the wmf_* modules.
//
// Usage:
//   req_* carries one RGB pixel per transaction; each is turned into grey
//   as (r+g+b)/3. The first six pixels after reset prime the window and give
//   no result; after that every third pixel yields one transaction on rsp_*
//   carrying the median of the current 3x3 window.
//   csr_we/csr_wdata set the row width in window positions (reset 512); write
//   it only while the block is idle.
// Throughput: one pixel per cycle sustained, one result every third pixel.
// Path: after the edge that accepts the third pixel of a group, the result
//   passes the queue, window update, row sort, column extremes and final
//   median stages before rsp_tvalid rises.
// Stall: when rsp_tready is low the median pipe holds, the queue fills and
//   req_tready drops once the queue (QUEUE_DEPTH entries) is full.
// Reset: synchronous; clears windows, counters, queue and pipe; there is no
//   clearing pass.
`default_nettype none

module window_median_filter_3x3_core #(
   parameter int unsigned QUEUE_DEPTH = wmf_pkg::QUEUE_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [wmf_pkg::CFG_W-1:0] csr_wdata,   // columns_per_row
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [23:0]               req_tdata,   // red, green, blue
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [7:0]                     rsp_tdata    // median_grey
);

   logic                q_ready, q_push, q_valid, q_pop;
   wmf_pkg::op_type     push_op, head_op;
   logic                med_ready, win_valid;
   wmf_pkg::window_type win;

   wmf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_op       (push_op)
   );

   wmf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_push),
      .in_ready  (q_ready),
      .in_op     (push_op),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_op    (head_op)
   );

   wmf_window u_window (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (q_valid),
      .op        (head_op),
      .op_pop    (q_pop),
      .med_ready (med_ready),
      .win_valid (win_valid),
      .win       (win)
   );

   wmf_median u_median (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (win_valid),
      .in_ready   (med_ready),
      .in_win     (win),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

/* rtl/wmf_front.sv */
// Front end: takes pixels, converts to grey, tracks priming, phase and column.
// Holds the row width register. Depends on wmf_pkg.
`default_nettype none

module wmf_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic [wmf_pkg::CFG_W-1:0]  csr_wdata,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [23:0]                req_tdata,
   input  wire logic                       q_ready,
   output logic                            q_push,
   output wmf_pkg::op_type                 q_op
);

   localparam logic [9:0] GREY_RECIP = 10'd683;
   localparam int unsigned GREY_SHIFT = 11;

   logic [wmf_pkg::CFG_W-1:0] cols_ff;
   logic [2:0]                prime_ff, prime_in;
   logic [1:0]                phase_ff, phase_in;
   logic [wmf_pkg::COL_W-1:0] col_ff, col_in;

   logic [9:0]                sum;
   logic [18:0]               prod;
   logic [wmf_pkg::CFG_W-1:0] width_eff;
   logic [wmf_pkg::CFG_W-1:0] col_next;
   logic                      accept;

   assign req_tready = q_ready;
   assign accept     = req_tvalid && q_ready;
   assign q_push     = accept;

   assign sum  = 10'(req_tdata[7:0]) + 10'(req_tdata[15:8]) + 10'(req_tdata[23:16]);
   assign prod = 19'(sum) * 19'(GREY_RECIP);

   always_comb begin
      if (cols_ff == '0) begin
         width_eff = wmf_pkg::CFG_W'(1);
      end else if (cols_ff > wmf_pkg::CFG_W'(wmf_pkg::MAX_COLUMNS)) begin
         width_eff = wmf_pkg::CFG_W'(wmf_pkg::MAX_COLUMNS);
      end else begin
         width_eff = cols_ff;
      end
   end

   assign col_next = {1'b0, col_ff} + wmf_pkg::CFG_W'(1);

   always_comb begin
      prime_in     = prime_ff;
      phase_in     = phase_ff;
      col_in       = col_ff;
      q_op.grey    = prod[GREY_SHIFT +: 8];
      q_op.kind    = wmf_pkg::OP_PRIME;
      q_op.slot    = prime_ff;
      q_op.last    = 1'b0;
      if (prime_ff < 3'(wmf_pkg::PRIME_PIXELS)) begin
         prime_in = prime_ff + 3'd1;
      end else begin
         q_op.kind = (col_ff == '0) ? wmf_pkg::OP_ROW_START : wmf_pkg::OP_SHIFT;
         q_op.slot = (phase_ff >= 2'd2) ? 3'd2 : {1'b0, phase_ff};
         q_op.last = (phase_ff >= 2'd2);
         if (phase_ff >= 2'd2) begin
            phase_in = 2'd0;
            col_in   = (col_next >= width_eff) ? '0 : col_next[wmf_pkg::COL_W-1:0];
         end else begin
            phase_in = phase_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= wmf_pkg::CFG_W'(wmf_pkg::CFG_RESET);
         prime_ff <= '0;
         phase_ff <= '0;
         col_ff   <= '0;
      end else begin
         if (csr_we) begin
            cols_ff <= csr_wdata;
         end
         if (accept) begin
            prime_ff <= prime_in;
            phase_ff <= phase_in;
            col_ff   <= col_in;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/wmf_queue.sv */
// Short queue of classified window operations between front and back.
// Depends on wmf_pkg for the operation type.
`default_nettype none

module wmf_queue #(
   parameter int unsigned DEPTH = wmf_pkg::QUEUE_DEPTH
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire wmf_pkg::op_type in_op,
   output logic                 out_valid,
   input  wire logic            out_pop,
   output wmf_pkg::op_type      out_op
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   wmf_pkg::op_type  mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;
   assign out_op    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not rise on push");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not fall on pop");

endmodule

`default_nettype wire

/* rtl/wmf_window.sv */
// Back end window store: applies queued operations to the row-start and
// working windows and hands finished windows to the median pipe. Uses wmf_pkg.
`default_nettype none

module wmf_window (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            op_valid,
   input  wire wmf_pkg::op_type op,
   output logic                 op_pop,
   input  wire logic            med_ready,
   output logic                 win_valid,
   output wmf_pkg::window_type  win
);

   localparam int unsigned IW = wmf_pkg::WIN_IDX_W;

   wmf_pkg::window_type rsw_ff, rsw_in;
   wmf_pkg::window_type wk_ff, wk_in;
   logic [IW-1:0]       prime_idx, bottom_idx;

   assign prime_idx  = IW'(3) + IW'(op.slot);
   assign bottom_idx = IW'(6) + IW'(op.slot[1:0]);

   always_comb begin
      rsw_in = rsw_ff;
      wk_in  = wk_ff;
      case (op.kind)
         wmf_pkg::OP_PRIME: begin
            rsw_in[prime_idx] = op.grey;
         end
         wmf_pkg::OP_ROW_START: begin
            if (op.slot[1:0] == 2'd0) begin
               for (int i = 0; i < 6; i++) begin
                  rsw_in[i] = rsw_ff[i+3];
                  wk_in[i]  = rsw_ff[i+3];
               end
            end
            rsw_in[bottom_idx] = op.grey;
            wk_in[bottom_idx]  = op.grey;
         end
         wmf_pkg::OP_SHIFT: begin
            for (int r = 0; r < 3; r++) begin
               if (op.slot[1:0] == 2'(r)) begin
                  wk_in[3*r]   = wk_ff[3*r+1];
                  wk_in[3*r+1] = wk_ff[3*r+2];
                  wk_in[3*r+2] = op.grey;
               end
            end
         end
         default: begin
            wk_in = wk_ff;
         end
      endcase
   end

   assign op_pop    = op_valid && (!op.last || med_ready);
   assign win_valid = op_valid && op.last;
   assign win       = wk_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsw_ff <= '0;
         wk_ff  <= '0;
      end else if (op_pop) begin
         rsw_ff <= rsw_in;
         wk_ff  <= wk_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/wmf_median.sv */
// Four-stage median-of-nine pipe: capture, sort rows, column extremes, final
// median into the result register. Depends on wmf_pkg for the window type.
`default_nettype none

module wmf_median (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire wmf_pkg::window_type in_win,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [7:0]               rsp_tdata
);

   function automatic wmf_pkg::grey_type min2(input wmf_pkg::grey_type a,
                                              input wmf_pkg::grey_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic wmf_pkg::grey_type max2(input wmf_pkg::grey_type a,
                                              input wmf_pkg::grey_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic wmf_pkg::grey_type med3(input wmf_pkg::grey_type a,
                                              input wmf_pkg::grey_type b,
                                              input wmf_pkg::grey_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   wmf_pkg::window_type win_ff, rows_ff, rows_in;
   wmf_pkg::grey_type   lo_ff, mid_ff, hi_ff;
   logic                v1_ff, v2_ff, v3_ff, out_v_ff;
   logic [7:0]          out_ff;
   logic                rdy1, rdy2, rdy3, rdy_out;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         rows_in[3*r]   = min2(min2(win_ff[3*r], win_ff[3*r+1]), win_ff[3*r+2]);
         rows_in[3*r+1] = med3(win_ff[3*r], win_ff[3*r+1], win_ff[3*r+2]);
         rows_in[3*r+2] = max2(max2(win_ff[3*r], win_ff[3*r+1]), win_ff[3*r+2]);
      end
   end

   assign rdy_out    = !out_v_ff || rsp_tready;
   assign rdy3       = !v3_ff || rdy_out;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign in_ready   = rdy1;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         win_ff <= in_win;
      end
      if (rdy2 && v1_ff) begin
         rows_ff <= rows_in;
      end
      if (rdy3 && v2_ff) begin
         lo_ff  <= max2(max2(rows_ff[0], rows_ff[3]), rows_ff[6]);
         mid_ff <= med3(rows_ff[1], rows_ff[4], rows_ff[7]);
         hi_ff  <= min2(min2(rows_ff[2], rows_ff[5]), rows_ff[8]);
      end
      if (rdy_out && v3_ff) begin
         out_ff <= med3(lo_ff, mid_ff, hi_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy_out) begin
            out_v_ff <= v3_ff;
         end
      end
   end

endmodule

`default_nettype wire
